// ===== src/cna_pkg.sv =====
// Shared types and constants for the complex number ALU.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cna_pkg;

  localparam int unsigned OUT_W    = 40;
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned Q_DEPTH  = 4;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_CONJ = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_MOD  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_CONJ = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_NONE = 3'd7
  } op_e;

  // Handshake between the front end and the item queue.
  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// ===== src/cna_front.sv =====
// Front end: accepts transactions, decodes the command and flags a zero divisor.
// Depends on cna_pkg.
`timescale 1ns / 1ps
module cna_front #(
  parameter int unsigned W = 16
) (
  input  logic [2:0]           cmd_i,
  input  logic signed [W-1:0]  a_re_i,
  input  logic signed [W-1:0]  a_im_i,
  input  logic signed [W-1:0]  b_re_i,
  input  logic signed [W-1:0]  b_im_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic                 q_full_i,
  output cna_pkg::q_ctl_t      q_ctl_o,
  output logic [4*W+3:0]       item_o
);
  import cna_pkg::*;

  op_e  op;
  logic bz;

  always_comb begin
    unique case (cmd_i)
      CMD_ADD:  op = OP_ADD;
      CMD_SUB:  op = OP_SUB;
      CMD_MUL:  op = OP_MUL;
      CMD_CONJ: op = OP_CONJ;
      CMD_DIV:  op = OP_DIV;
      CMD_MOD:  op = OP_MOD;
      default:  op = OP_NONE;
    endcase
  end

  assign bz           = (b_re_i == '0) && (b_im_i == '0);
  assign item_o       = {op, bz, a_re_i, a_im_i, b_re_i, b_im_i};
  assign full_o       = q_full_i;
  assign q_ctl_o.push = push_i && !q_full_i;
  assign q_ctl_o.full = q_full_i;

endmodule

// ===== src/cna_fifo.sv =====
// Short item queue between the front end and the execution pipeline.
// Depends on cna_pkg for the handshake struct.
`timescale 1ns / 1ps
module cna_fifo #(
  parameter int unsigned WIDTH = 68,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cna_pkg::q_ctl_t  ctl_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);
  import cna_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (ctl_i.push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (ctl_i.push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!ctl_i.push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/cna_back.sv =====
// Execution pipeline: products, sums, one divider step per stage with a square root step
// in the leading stages, then scaling, saturation and the output register. Depends on cna_pkg.
`timescale 1ns / 1ps
module cna_back #(
  parameter int unsigned W = 16,
  parameter int unsigned F = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  logic [4*W+3:0]               head_data_i,
  output logic                         take_o,
  output logic signed [cna_pkg::OUT_W-1:0] res_re_o,
  output logic signed [cna_pkg::OUT_W-1:0] res_im_o,
  output logic [1:0]                   status_o,
  output logic                         empty_o,
  input  logic                         pop_i
);
  import cna_pkg::*;

  localparam int unsigned PW    = 2 * W;
  localparam int unsigned DW    = 2 * W + 1;
  localparam int unsigned QB    = 2 * W + OUT_FRAC;
  localparam int unsigned SH    = 2 * OUT_FRAC - 2 * F;
  localparam int unsigned VW    = 2 * W + SH;
  localparam int unsigned RB    = (VW + 1) / 2;
  localparam int unsigned RV    = 2 * RB;
  localparam int unsigned RMW   = RB + 2;
  localparam int unsigned XW    = 2 * W + OUT_FRAC + 1;
  localparam int unsigned CW    = (XW > OUT_W + 1) ? XW : OUT_W + 1;
  localparam int unsigned LIN_L = OUT_FRAC - F;
  localparam int unsigned MUL_R = (2 * F > OUT_FRAC) ? 2 * F - OUT_FRAC : 0;
  localparam int unsigned MUL_L = (2 * F < OUT_FRAC) ? OUT_FRAC - 2 * F : 0;

  typedef struct packed {
    logic            v;
    op_e             op;
    logic            bz;
    logic            dneg_re;
    logic            dneg_im;
    logic [DW-1:0]   dmag_re;
    logic [DW-1:0]   dmag_im;
    logic            qneg_re;
    logic            qneg_im;
    logic [PW-1:0]   rem_re;
    logic [PW-1:0]   rem_im;
    logic [QB-1:0]   nq_re;
    logic [QB-1:0]   nq_im;
    logic [PW-1:0]   den;
    logic [RMW-1:0]  srem;
    logic [RB-1:0]   root;
    logic [RV-1:0]   rad;
  } stg_t;

  function automatic stg_t div_step(stg_t s);
    logic [PW:0] t_re, t_im;
    logic        ge_re, ge_im;
    stg_t        o;
    o     = s;
    t_re  = {s.rem_re, s.nq_re[QB-1]};
    t_im  = {s.rem_im, s.nq_im[QB-1]};
    ge_re = (t_re >= {1'b0, s.den});
    ge_im = (t_im >= {1'b0, s.den});
    o.rem_re = ge_re ? PW'(t_re - {1'b0, s.den}) : t_re[PW-1:0];
    o.rem_im = ge_im ? PW'(t_im - {1'b0, s.den}) : t_im[PW-1:0];
    o.nq_re  = {s.nq_re[QB-2:0], ge_re};
    o.nq_im  = {s.nq_im[QB-2:0], ge_im};
    return o;
  endfunction

  function automatic stg_t root_step(stg_t s);
    logic [RMW+1:0] t, trial;
    logic           ge;
    stg_t           o;
    o     = s;
    t     = {s.srem, s.rad[RV-1 -: 2]};
    trial = (RMW+2)'({s.root, 2'b01});
    ge    = (t >= trial);
    o.srem = ge ? RMW'(t - trial) : t[RMW-1:0];
    o.root = {s.root[RB-2:0], ge};
    o.rad  = s.rad << 2;
    return o;
  endfunction

  // Scale-aligned magnitude in, saturate and apply sign; top bit flags saturation.
  function automatic logic [OUT_W:0] fin(logic neg, logic [CW-1:0] m);
    logic [CW-1:0]    lim, mm;
    logic             sat;
    logic [OUT_W-1:0] v;
    lim = neg ? (CW'(1) << (OUT_W - 1)) : ((CW'(1) << (OUT_W - 1)) - CW'(1));
    sat = (m > lim);
    mm  = sat ? lim : m;
    v   = neg ? (~mm[OUT_W-1:0] + 1'b1) : mm[OUT_W-1:0];
    return {sat, v};
  endfunction

  logic adv;
  logic out_v_q;

  assign adv    = !out_v_q || pop_i;
  assign take_o = adv && head_valid_i;

  // Product stage
  op_e                hd_op;
  logic signed [W-1:0] hd_ar, hd_ai, hd_br, hd_bi, sq_x, sq_y;

  assign hd_op = op_e'(head_data_i[4*W+3 -: 3]);
  assign hd_ar = $signed(head_data_i[4*W-1 -: W]);
  assign hd_ai = $signed(head_data_i[3*W-1 -: W]);
  assign hd_br = $signed(head_data_i[2*W-1 -: W]);
  assign hd_bi = $signed(head_data_i[W-1:0]);
  assign sq_x  = (hd_op == OP_MOD) ? hd_ar : hd_br;
  assign sq_y  = (hd_op == OP_MOD) ? hd_ai : hd_bi;

  logic                 v1_q, bz1_q;
  op_e                  op1_q;
  logic signed [W-1:0]  ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [PW-1:0] rr1_q, ii1_q, ri1_q, ir1_q, sx1_q, sy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= hd_op;
      bz1_q <= head_data_i[4*W];
      ar1_q <= hd_ar;
      ai1_q <= hd_ai;
      br1_q <= hd_br;
      bi1_q <= hd_bi;
      rr1_q <= PW'(hd_ar) * PW'(hd_br);
      ii1_q <= PW'(hd_ai) * PW'(hd_bi);
      ri1_q <= PW'(hd_ar) * PW'(hd_bi);
      ir1_q <= PW'(hd_ai) * PW'(hd_br);
      sx1_q <= PW'(sq_x) * PW'(sq_x);
      sy1_q <= PW'(sq_y) * PW'(sq_y);
    end
  end

  // Sum stage: build the entry of the step pipeline
  logic signed [W:0]    lin_re, lin_im;
  logic signed [DW-1:0] d_re, d_im, num_re, num_im;
  logic [PW-1:0]        sq_sum;
  stg_t                 stg_d [QB+1];
  stg_t                 stg_q [QB+1];

  always_comb begin
    case (op1_q)
      OP_ADD: begin
        lin_re = (W+1)'(ar1_q) + (W+1)'(br1_q);
        lin_im = (W+1)'(ai1_q) + (W+1)'(bi1_q);
      end
      OP_SUB: begin
        lin_re = (W+1)'(ar1_q) - (W+1)'(br1_q);
        lin_im = (W+1)'(ai1_q) - (W+1)'(bi1_q);
      end
      default: begin
        lin_re = (W+1)'(ar1_q);
        lin_im = -((W+1)'(ai1_q));
      end
    endcase
    d_re   = (op1_q == OP_MUL) ? (DW'(rr1_q) - DW'(ii1_q)) : DW'(lin_re);
    d_im   = (op1_q == OP_MUL) ? (DW'(ri1_q) + DW'(ir1_q)) : DW'(lin_im);
    num_re = DW'(rr1_q) + DW'(ii1_q);
    num_im = DW'(ir1_q) - DW'(ri1_q);
    sq_sum = PW'($unsigned(sx1_q) + $unsigned(sy1_q));

    stg_d[0]         = '0;
    stg_d[0].v       = v1_q;
    stg_d[0].op      = op1_q;
    stg_d[0].bz      = bz1_q;
    stg_d[0].dneg_re = d_re[DW-1];
    stg_d[0].dneg_im = d_im[DW-1];
    stg_d[0].dmag_re = d_re[DW-1] ? DW'(-d_re) : DW'(d_re);
    stg_d[0].dmag_im = d_im[DW-1] ? DW'(-d_im) : DW'(d_im);
    stg_d[0].qneg_re = num_re[DW-1];
    stg_d[0].qneg_im = num_im[DW-1];
    stg_d[0].nq_re   = QB'(num_re[DW-1] ? PW'(-num_re) : PW'(num_re)) << OUT_FRAC;
    stg_d[0].nq_im   = QB'(num_im[DW-1] ? PW'(-num_im) : PW'(num_im)) << OUT_FRAC;
    stg_d[0].den     = sq_sum;
    stg_d[0].rad     = RV'(sq_sum) << SH;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    if (k < RB) begin : g_both
      always_comb stg_d[k+1] = root_step(div_step(stg_q[k]));
    end else begin : g_div
      always_comb stg_d[k+1] = div_step(stg_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QB; i++) begin
        stg_q[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i <= QB; i++) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  // Finish stage
  stg_t             last;
  logic [OUT_W:0]   f_re, f_im;
  logic [OUT_W-1:0] re_d, im_d;
  logic [1:0]       st_d;

  assign last = stg_q[QB];

  always_comb begin
    f_re = '0;
    f_im = '0;
    st_d = ST_OK;
    unique case (last.op) inside
      OP_ADD, OP_SUB, OP_CONJ: begin
        f_re = fin(last.dneg_re, CW'(last.dmag_re) << LIN_L);
        f_im = fin(last.dneg_im, CW'(last.dmag_im) << LIN_L);
      end
      OP_MUL: begin
        f_re = fin(last.dneg_re, (CW'(last.dmag_re) >> MUL_R) << MUL_L);
        f_im = fin(last.dneg_im, (CW'(last.dmag_im) >> MUL_R) << MUL_L);
      end
      OP_DIV: begin
        if (last.bz) begin
          st_d = ST_DIV0;
        end else begin
          f_re = fin(last.qneg_re, CW'(last.nq_re));
          f_im = fin(last.qneg_im, CW'(last.nq_im));
        end
      end
      OP_MOD: begin
        f_re = fin(1'b0, CW'(last.root));
      end
      default: begin
        f_re = '0;
      end
    endcase
    if (st_d == ST_OK && (f_re[OUT_W] || f_im[OUT_W])) begin
      st_d = ST_SAT;
    end
    re_d = f_re[OUT_W-1:0];
    im_d = f_im[OUT_W-1:0];
  end

  logic [OUT_W-1:0] re_q, im_q;
  logic [1:0]       st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= last.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q <= re_d;
      im_q <= im_d;
      st_q <= st_d;
    end
  end

  assign res_re_o = $signed(re_q);
  assign res_im_o = $signed(im_q);
  assign status_o = st_q;
  assign empty_o  = !out_v_q;

endmodule

// ===== src/complex_number_alu_top.sv =====
// Complex number ALU: add, subtract, multiply, conjugate, divide, modulus.
// Throughput: one transaction per cycle while the output can move; the divider takes one
// bit per pipeline stage over 2*IN_WIDTH+16 stages, the square root one bit per stage in
// the leading part of them, and all stages advance together while the output can move.
// Reset (rst_ni low, asynchronous) empties the queue and the pipeline.
// Instantiates cna_front, cna_fifo and cna_back; depends on cna_pkg.
`timescale 1ns / 1ps
module complex_number_alu_top #(
  parameter int unsigned IN_WIDTH     = 16,
  parameter int unsigned IN_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [2:0]                        cmd_i,
  input  logic signed [IN_WIDTH-1:0]        a_re_i,
  input  logic signed [IN_WIDTH-1:0]        a_im_i,
  input  logic signed [IN_WIDTH-1:0]        b_re_i,
  input  logic signed [IN_WIDTH-1:0]        b_im_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [cna_pkg::OUT_W-1:0]  res_re_o,
  output logic signed [cna_pkg::OUT_W-1:0]  res_im_o,
  output logic [1:0]                        status_o
);
  import cna_pkg::*;

  localparam int unsigned IW = 4 * IN_WIDTH + 4;

  q_ctl_t          q_ctl;
  logic            q_full, q_valid, q_take;
  logic [IW-1:0]   item, head;

  cna_front #(.W(IN_WIDTH)) u_front (
    .cmd_i    (cmd_i),
    .a_re_i   (a_re_i),
    .a_im_i   (a_im_i),
    .b_re_i   (b_re_i),
    .b_im_i   (b_im_i),
    .push_i   (push),
    .full_o   (full),
    .q_full_i (q_full),
    .q_ctl_o  (q_ctl),
    .item_o   (item)
  );

  cna_fifo #(.WIDTH(IW), .DEPTH(Q_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (q_ctl),
    .data_i  (item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_take),
    .data_o  (head)
  );

  cna_back #(.W(IN_WIDTH), .F(IN_FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_data_i  (head),
    .take_o       (q_take),
    .res_re_o     (res_re_o),
    .res_im_o     (res_im_o),
    .status_o     (status_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule

// ===== tb/sv/tb_complex_number_alu_top.sv =====
// Self-checking testbench for complex_number_alu_top: directed and random
// transactions, with an in-line predictor of the fixed-point complex arithmetic.
// Depends on cna_pkg and complex_number_alu_top.
`timescale 1ns / 1ps
module tb_complex_number_alu_top;
  import cna_pkg::*;

  localparam int unsigned IW        = 16;
  localparam int unsigned N_RANDOM  = 1230;
  localparam int unsigned LIMIT     = 400000;
  localparam int unsigned DRAIN_CYC = 80;

  typedef struct {
    logic [2:0]           cmd;
    logic signed [IW-1:0] a_re;
    logic signed [IW-1:0] a_im;
    logic signed [IW-1:0] b_re;
    logic signed [IW-1:0] b_im;
  } operands_t;

  typedef struct {
    logic [OUT_W-1:0] re;
    logic [OUT_W-1:0] im;
    logic [1:0]       status;
  } cresult_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [2:0]           cmd_i;
  logic signed [IW-1:0] a_re_i, a_im_i, b_re_i, b_im_i;
  logic                 empty;
  logic                 pop;
  logic signed [OUT_W-1:0] res_re_o, res_im_o;
  logic [1:0]           status_o;

  operands_t pending_ops[$];
  cresult_t  expected_results[$];
  int unsigned n_accepted;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt;
  bit          hold_done;

  complex_number_alu_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .cmd_i   (cmd_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .empty   (empty),
    .pop     (pop),
    .res_re_o(res_re_o),
    .res_im_o(res_im_o),
    .status_o(status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp to the 40-bit output range and flag saturation.
  function automatic logic [OUT_W-1:0] clamp_out(longint v, inout bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo = -(longint'(1) <<< (OUT_W - 1));
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    return v[OUT_W-1:0];
  endfunction

  // Quotient num * 2^16 / den, truncated toward zero.
  function automatic longint div_q16(longint num, longint den);
    longint unsigned mag;
    mag = ((num < 0 ? -num : num) <<< OUT_FRAC) / den;
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic cresult_t complex_result(operands_t op);
    cresult_t r;
    bit sat;
    longint ar, ai, br, bi, den;
    longint unsigned sq, lo, hi, mid;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    sat = 1'b0;
    r.re = '0;
    r.im = '0;
    r.status = ST_OK;
    case (op.cmd)
      CMD_ADD: begin
        r.re = clamp_out((ar + br) <<< 8, sat);
        r.im = clamp_out((ai + bi) <<< 8, sat);
      end
      CMD_SUB: begin
        r.re = clamp_out((ar - br) <<< 8, sat);
        r.im = clamp_out((ai - bi) <<< 8, sat);
      end
      CMD_MUL: begin
        r.re = clamp_out(ar * br - ai * bi, sat);
        r.im = clamp_out(ar * bi + ai * br, sat);
      end
      CMD_CONJ: begin
        r.re = clamp_out(ar <<< 8, sat);
        r.im = clamp_out((-ai) <<< 8, sat);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DIV0;
        end else begin
          r.re = clamp_out(div_q16(ar * br + ai * bi, den), sat);
          r.im = clamp_out(div_q16(ai * br - ar * bi, den), sat);
        end
      end
      CMD_MOD: begin
        sq = longint'(ar * ar + ai * ai) << 16;
        lo = 0;
        hi = 64'd1 << 25;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (mid * mid <= sq) lo = mid;
          else hi = mid - 1;
        end
        r.re = clamp_out(longint'(lo), sat);
      end
      default: ;
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  function automatic logic signed [IW-1:0] rand_part();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1:       return '0;
      2:       return IW'($signed($urandom_range(16)) - 8);
      default: return IW'($urandom);
    endcase
  endfunction

  function automatic operands_t make_ops(int c, int ar, int ai, int br, int bi);
    operands_t op;
    op.cmd = 3'(c);
    op.a_re = IW'(ar);
    op.a_im = IW'(ai);
    op.b_re = IW'(br);
    op.b_im = IW'(bi);
    return op;
  endfunction

  // Driver: advance on each accepted transaction, idle at random outside a stretch of gapless pushes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      cmd_i <= '0;
      a_re_i <= '0;
      a_im_i <= '0;
      b_re_i <= '0;
      b_im_i <= '0;
      n_accepted <= 0;
    end else begin
      if (push && !full) begin
        expected_results.push_back(complex_result(pending_ops.pop_front()));
        n_accepted <= n_accepted + 1;
      end
      if (pending_ops.size() > 0 &&
          ((n_accepted > 400 && n_accepted < 700) || $urandom_range(99) >= 7)) begin
        push <= 1'b1;
        cmd_i <= pending_ops[0].cmd;
        a_re_i <= pending_ops[0].a_re;
        a_im_i <= pending_ops[0].a_im;
        b_re_i <= pending_ops[0].b_re;
        b_im_i <= pending_ops[0].b_im;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Hold off once for a long stretch so the block backs up and raises full.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 150) begin
      hold_done <= 1'b1;
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: compare each popped transaction with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    cresult_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10) $display("unexpected result re=%h im=%h st=%0d",
                                      res_re_o, res_im_o, status_o);
        end else begin
          want = expected_results.pop_front();
          if (want.re !== res_re_o || want.im !== res_im_o || want.status !== status_o) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10)
              $display("result differs: want re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                       want.re, want.im, want.status, res_re_o, res_im_o, status_o);
          end
        end
      end
      if (hold_cnt > 0 || (!hold_done && n_accepted >= 150)) begin
        pop <= 1'b0;
      end else begin
        pop <= (n_accepted > 400 && n_accepted < 700) || $urandom_range(99) >= 7;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("complex_number_alu_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    pending_ops.push_back(make_ops(CMD_ADD, 32767, 32767, 32767, 32767));
    pending_ops.push_back(make_ops(CMD_ADD, -32768, -32768, -32768, -32768));
    pending_ops.push_back(make_ops(CMD_SUB, 32767, -32768, -32768, 32767));
    pending_ops.push_back(make_ops(CMD_SUB, -32768, 32767, 32767, -32768));
    pending_ops.push_back(make_ops(CMD_MUL, -32768, -32768, -32768, -32768));
    pending_ops.push_back(make_ops(CMD_MUL, -32768, 32767, 32767, -32768));
    pending_ops.push_back(make_ops(CMD_MUL, 256, 0, 0, 256));
    pending_ops.push_back(make_ops(CMD_CONJ, -32768, -32768, 5, 5));
    pending_ops.push_back(make_ops(CMD_CONJ, 32767, 0, 0, 0));
    pending_ops.push_back(make_ops(CMD_DIV, 1000, -2000, 0, 0));
    pending_ops.push_back(make_ops(CMD_DIV, 0, 0, 0, 0));
    pending_ops.push_back(make_ops(CMD_DIV, -32768, -32768, 1, 0));
    pending_ops.push_back(make_ops(CMD_DIV, 32767, -32768, 0, -1));
    pending_ops.push_back(make_ops(CMD_DIV, -7, 3, 32767, -32768));
    pending_ops.push_back(make_ops(CMD_DIV, 256, 256, 256, -256));
    pending_ops.push_back(make_ops(CMD_MOD, -32768, -32768, 0, 0));
    pending_ops.push_back(make_ops(CMD_MOD, 0, 0, 0, 0));
    pending_ops.push_back(make_ops(CMD_MOD, 3, -4, 0, 0));
    pending_ops.push_back(make_ops(CMD_MOD, 1, 1, 0, 0));
    pending_ops.push_back(make_ops(6, 123, 456, 789, 1011));
    pending_ops.push_back(make_ops(7, -1, -1, -1, -1));
    for (int i = 0; i < N_RANDOM; i++) begin
      operands_t op;
      op.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      op.a_re = rand_part();
      op.a_im = rand_part();
      op.b_re = rand_part();
      op.b_im = rand_part();
      if ($urandom_range(29) == 0) begin
        op.b_re = '0;
        op.b_im = '0;
      end
      pending_ops.push_back(op);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0 && !push);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("complex_number_alu_top: match");
    end else begin
      $display("complex_number_alu_top: mismatch");
    end
    $finish;
  end

endmodule
